/* hw/rtl/cfp_pkg.sv */
`default_nettype none

package cfp_pkg;

    // Default accumulator width and fixed result widths
    localparam int SEQ_WIDTH_DEF = 32;
    localparam int SEQ_EXT_W     = 64;
    localparam int OUT_SEQ_W     = 32;
    localparam int KW_COUNT      = 4;
    localparam int POS_W         = 4;

    // Character codes used by the frame grammar
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Command codes carried in the result
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_OPEN    = 3'd1,
        ACT_GRAB    = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_STOP    = 3'd4
    } action_t;

    typedef struct packed {
        logic                 frame_ok;
        logic [OUT_SEQ_W-1:0] seq_number;
        action_t              action;
    } cfp_result_t;

    // "SEQ:" header
    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] ch;
        case (pos)
            2'd0:    ch = "S";
            2'd1:    ch = "E";
            2'd2:    ch = "Q";
            default: ch = ":";
        endcase
        return ch;
    endfunction

    // " CMD:" separator
    function automatic logic [7:0] sep_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = " ";
            3'd1:    ch = "C";
            3'd2:    ch = "M";
            3'd3:    ch = "D";
            3'd4:    ch = ":";
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [POS_W-1:0] kw_len(input logic [1:0] k);
        logic [POS_W-1:0] len;
        case (k)
            2'd2:    len = POS_W'(12);
            default: len = POS_W'(9);
        endcase
        return len;
    endfunction

    // Keyword characters; all share the "HAND_" stem
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        case (pos)
            4'd0: ch = "H";
            4'd1: ch = "A";
            4'd2: ch = "N";
            4'd3: ch = "D";
            4'd4: ch = "_";
            default:
            begin
                case (k)
                    2'd0:
                    begin
                        case (pos)
                            4'd5:    ch = "O";
                            4'd6:    ch = "P";
                            4'd7:    ch = "E";
                            4'd8:    ch = "N";
                            default: ch = CH_NUL;
                        endcase
                    end
                    2'd1:
                    begin
                        case (pos)
                            4'd5:    ch = "G";
                            4'd6:    ch = "R";
                            4'd7:    ch = "A";
                            4'd8:    ch = "B";
                            default: ch = CH_NUL;
                        endcase
                    end
                    2'd2:
                    begin
                        case (pos)
                            4'd5:    ch = "R";
                            4'd6:    ch = "E";
                            4'd7:    ch = "L";
                            4'd8:    ch = "E";
                            4'd9:    ch = "A";
                            4'd10:   ch = "S";
                            4'd11:   ch = "E";
                            default: ch = CH_NUL;
                        endcase
                    end
                    default:
                    begin
                        case (pos)
                            4'd5:    ch = "S";
                            4'd6:    ch = "T";
                            4'd7:    ch = "O";
                            4'd8:    ch = "P";
                            default: ch = CH_NUL;
                        endcase
                    end
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/command_frame_parser.sv */
`default_nettype none

// Command frame parser: checks text lines of the form "SEQ:<number> CMD:<keyword>"
// arriving one byte per transfer on the slave stream (s_tlast marks the final byte
// of a line). One result transfer leaves the master stream per line, carrying the
// frame_ok flag in m_tuser and the sequence number and action code in m_tdata.
// A byte is registered on input and then parsed, and the result of a line is
// registered for output, so bytes stream in back to back at one per clock unless
// the input stalls. The input stalls only while a finished result waits on m_tready
// and another line end is ready to be parsed. SEQ_WIDTH sets the accumulator width;
// the low 32 bits of the number are reported.
module command_frame_parser #(
    parameter int SEQ_WIDTH = cfp_pkg::SEQ_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic        s_tlast,   // line_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] seq_number, [34:32] action, rest zero
    output logic             m_tuser    // frame_ok
);
    import cfp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    cfp_result_t  out_res_reg;
    cfp_result_t  parse_res;
    logic         out_free;
    logic         advance;

    // Move a byte into the parser when the result slot allows it
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    cfp_parser #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_byte (in_byte_reg),
        .line_end  (in_last_reg),
        .result    (parse_res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_res_reg <= parse_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.frame_ok;
    assign m_tdata  = {5'b0, out_res_reg.action, out_res_reg.seq_number};

endmodule

`default_nettype wire

/* hw/rtl/cfp_parser.sv */
`default_nettype none

module cfp_parser #(
    parameter int SEQ_WIDTH = cfp_pkg::SEQ_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          char_byte,
    input  wire logic                line_end,
    output cfp_pkg::cfp_result_t     result
);
    import cfp_pkg::*;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_SPACE,
        PH_NEED_DIGIT,
        PH_DIGITS,
        PH_SEP,
        PH_KEYWORD,
        PH_ENDED
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [SEQ_WIDTH-1:0]   acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;
    logic                   minus_reg, minus_next;
    logic [KW_COUNT-1:0]    cand_reg, cand_next;
    logic                   failed_reg, failed_next;

    logic                   is_digit;
    logic                   is_ws;
    logic [3:0]             digit_val;
    logic [SEQ_WIDTH+3:0]   acc_times10;
    logic [KW_COUNT-1:0]    live;
    action_t                act_cur;
    action_t                act_end;
    logic [SEQ_WIDTH-1:0]   seq_val;
    logic [SEQ_EXT_W-1:0]   seq_ext;

    // First live candidate whose full length has been seen
    function automatic action_t match_action(input logic [KW_COUNT-1:0] cand,
                                             input logic [POS_W-1:0] pos);
        action_t act;
        act = ACT_NONE;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (cand[k] && kw_len(2'(k)) == pos)
            begin
                act = action_t'(3'(k + 1));
            end
        end
        return act;
    endfunction

    // Character classes and the decimal step
    always_comb
    begin
        is_digit    = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
        is_ws       = (char_byte == CH_SPACE) || ((char_byte >= CH_TAB) && (char_byte <= CH_CR));
        digit_val   = 4'(char_byte - CH_ZERO);
        acc_times10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + (SEQ_WIDTH+4)'(digit_val);
        for (int k = 0; k < KW_COUNT; k++)
        begin
            live[k] = cand_reg[k] && (pos_reg < kw_len(2'(k)))
                    && (char_byte == kw_char(2'(k), pos_reg));
        end
        act_cur = match_action(cand_reg, pos_reg);
    end

    // Next parse state for one character
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        minus_next  = minus_reg;
        cand_next   = cand_reg;
        failed_next = failed_reg;

        if (!failed_reg && phase_reg != PH_ENDED)
        begin
            if (char_byte == CH_NUL)
            begin
                if (phase_reg == PH_KEYWORD && act_cur != ACT_NONE)
                begin
                    phase_next = PH_ENDED;
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_PREFIX:
                    begin
                        if (char_byte == prefix_char(pos_reg[1:0]))
                        begin
                            if (pos_reg == POS_W'(3))
                            begin
                                phase_next = PH_SPACE;
                                pos_next   = '0;
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_SPACE, PH_NEED_DIGIT, PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            phase_next = PH_DIGITS;
                            if (!ovf_reg)
                            begin
                                if (acc_times10[SEQ_WIDTH+3:SEQ_WIDTH] != 4'd0)
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    acc_next = acc_times10[SEQ_WIDTH-1:0];
                                end
                            end
                        end
                        else if (phase_reg == PH_SPACE && is_ws)
                        begin
                            // skip leading whitespace
                        end
                        else if (phase_reg == PH_SPACE && char_byte == CH_PLUS)
                        begin
                            phase_next = PH_NEED_DIGIT;
                        end
                        else if (phase_reg == PH_SPACE && char_byte == CH_MINUS)
                        begin
                            minus_next = 1'b1;
                            phase_next = PH_NEED_DIGIT;
                        end
                        else if (phase_reg == PH_DIGITS && char_byte == sep_char(3'd0))
                        begin
                            phase_next = PH_SEP;
                            pos_next   = POS_W'(1);
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_SEP:
                    begin
                        if (pos_reg < POS_W'(5) && char_byte == sep_char(pos_reg[2:0]))
                        begin
                            if (pos_reg == POS_W'(4))
                            begin
                                phase_next = PH_KEYWORD;
                                pos_next   = '0;
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_KEYWORD:
                    begin
                        cand_next = live;
                        if (live == '0)
                        begin
                            failed_next = 1'b1;
                        end
                        else if (pos_reg != '1)
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Judge the frame at the last byte; the number never changes on a valid last byte
    always_comb
    begin
        if (!failed_next && (phase_next == PH_KEYWORD || phase_next == PH_ENDED))
        begin
            act_end = match_action(cand_next, pos_next);
        end
        else
        begin
            act_end = ACT_NONE;
        end

        if (ovf_reg)
        begin
            seq_val = '1;
        end
        else if (minus_reg)
        begin
            seq_val = '0 - acc_reg;
        end
        else
        begin
            seq_val = acc_reg;
        end
        seq_ext = SEQ_EXT_W'(seq_val);

        result.frame_ok   = (act_end != ACT_NONE);
        result.action     = act_end;
        result.seq_number = (act_end != ACT_NONE) ? seq_ext[OUT_SEQ_W-1:0] : '0;
    end

    // Hold parse state; clear it after each line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PREFIX;
            pos_reg    <= '0;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            minus_reg  <= 1'b0;
            cand_reg   <= '1;
            failed_reg <= 1'b0;
        end
        else if (step)
        begin
            if (line_end)
            begin
                phase_reg  <= PH_PREFIX;
                pos_reg    <= '0;
                acc_reg    <= '0;
                ovf_reg    <= 1'b0;
                minus_reg  <= 1'b0;
                cand_reg   <= '1;
                failed_reg <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                acc_reg    <= acc_next;
                ovf_reg    <= ovf_next;
                minus_reg  <= minus_next;
                cand_reg   <= cand_next;
                failed_reg <= failed_next;
            end
        end
    end

endmodule

`default_nettype wire
